// ----- sv/hcbp_pkg.sv -----
// Shared types and constants for the code bit packer.
package hcbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W = 6;
    localparam int SYM_W = 8;
    localparam int WIN_W = CODE_W + 8;
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOL_COUNT = 256;

    localparam logic [1:0] CMD_ENCODE = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } job_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

endpackage

// ----- sv/hcbp_fifo.sv -----
// Small register-based first-in first-out queue.
module hcbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/hcbp_front.sv -----
// Front end: accepts requests, holds the code table and issues packing jobs.
module hcbp_front #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [1:0]                              cmd,
    input  logic [hcbp_pkg::SYM_W-1:0]              symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]             code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]              code_length,
    input  logic [$clog2(hcbp_pkg::JOB_DEPTH+1)-1:0] job_count,
    output logic                                    job_push,
    output hcbp_pkg::job_t                          job
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int EFF_MAX = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                : hcbp_pkg::CODE_W;
    localparam int ENT_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    logic [ENT_W-1:0]        mem_reg [SYMBOL_COUNT];
    logic [ENT_W-1:0]        rd_reg;
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic                    s1_valid_reg;
    logic                    s1_flush_reg;
    logic                    s1_hit_reg;
    logic                    accept;
    logic                    in_range;
    logic [AW-1:0]           addr;
    logic [hcbp_pkg::LEN_W-1:0] len_sat;

    assign full     = (32'(job_count) + 32'(s1_valid_reg)) >= 32'(hcbp_pkg::JOB_DEPTH);
    assign accept   = push && !full;
    assign in_range = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign addr     = symbol[AW-1:0];
    assign len_sat  = (code_length > hcbp_pkg::LEN_W'(EFF_MAX))
                      ? hcbp_pkg::LEN_W'(EFF_MAX) : code_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
            s1_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && ((cmd == hcbp_pkg::CMD_ENCODE)
                                       || (cmd == hcbp_pkg::CMD_FLUSH));
            s1_flush_reg <= (cmd == hcbp_pkg::CMD_FLUSH);
            s1_hit_reg   <= in_range && valid_reg[addr];
            if (accept && (cmd == hcbp_pkg::CMD_LOAD) && in_range)
            begin
                valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == hcbp_pkg::CMD_LOAD) && in_range)
        begin
            mem_reg[addr] <= {code_bits, len_sat};
        end
        if (accept && (cmd == hcbp_pkg::CMD_ENCODE))
        begin
            rd_reg <= mem_reg[addr];
        end
    end

    always_comb
    begin
        job_push  = s1_valid_reg;
        job.flush = s1_flush_reg;
        job.code  = rd_reg[ENT_W-1:hcbp_pkg::LEN_W];
        job.len   = (s1_hit_reg && !s1_flush_reg) ? rd_reg[hcbp_pkg::LEN_W-1:0] : '0;
    end

endmodule

// ----- sv/hcbp_back.sv -----
// Back end: appends code bits to the byte buffer and emits finished bytes.
module hcbp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_empty,
    input  hcbp_pkg::job_t job,
    output logic           job_pop,
    input  logic           out_full,
    output logic           out_push,
    output hcbp_pkg::out_t out_item
);

    hcbp_pkg::back_state_t state_reg;
    hcbp_pkg::back_state_t state_next;

    logic [hcbp_pkg::WIN_W-1:0]  win_reg;
    logic [2:0]                  left_reg;
    logic [2:0]                  rem_reg;
    logic [7:0]                  pend_bits_reg;
    logic [2:0]                  pend_cnt_reg;
    logic [hcbp_pkg::CODE_W-1:0] code_al;
    logic [hcbp_pkg::WIN_W-1:0]  win_new;
    logic [hcbp_pkg::LEN_W-1:0]  total;
    logic [2:0]                  nbytes;
    logic [2:0]                  rem_new;

    always_comb
    begin
        code_al = job.code << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - job.len);
        win_new = {pend_bits_reg, {hcbp_pkg::CODE_W{1'b0}}}
                  | ({code_al, 8'b0} >> pend_cnt_reg);
        total   = {{(hcbp_pkg::LEN_W - 3){1'b0}}, pend_cnt_reg} + job.len;
        if (job.flush)
        begin
            nbytes  = (pend_cnt_reg != 3'd0) ? 3'd1 : 3'd0;
            rem_new = 3'd0;
        end
        else
        begin
            nbytes  = total[5:3];
            rem_new = total[2:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcbp_pkg::BK_IDLE:
            begin
                if (!job_empty && (nbytes != 3'd0))
                begin
                    state_next = hcbp_pkg::BK_EMIT;
                end
            end
            hcbp_pkg::BK_EMIT:
            begin
                if (!out_full && (left_reg == 3'd1))
                begin
                    state_next = hcbp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_pop       = 1'b0;
        out_push      = 1'b0;
        out_item.data = win_reg[hcbp_pkg::WIN_W-1 -: 8];
        out_item.last = (left_reg == 3'd1);
        unique case (state_reg)
            hcbp_pkg::BK_IDLE:
            begin
                job_pop = !job_empty;
            end
            hcbp_pkg::BK_EMIT:
            begin
                out_push = !out_full;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcbp_pkg::BK_IDLE;
            left_reg      <= 3'd0;
            rem_reg       <= 3'd0;
            pend_bits_reg <= 8'd0;
            pend_cnt_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hcbp_pkg::BK_IDLE && !job_empty)
            begin
                left_reg <= nbytes;
                rem_reg  <= rem_new;
                if (nbytes == 3'd0)
                begin
                    pend_bits_reg <= win_new[hcbp_pkg::WIN_W-1 -: 8];
                    pend_cnt_reg  <= rem_new;
                end
            end
            else if (state_reg == hcbp_pkg::BK_EMIT && !out_full)
            begin
                left_reg <= left_reg - 3'd1;
                if (left_reg == 3'd1)
                begin
                    pend_bits_reg <= win_reg[hcbp_pkg::WIN_W-9 -: 8];
                    pend_cnt_reg  <= rem_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hcbp_pkg::BK_IDLE && !job_empty)
        begin
            win_reg <= win_new;
        end
        else if (state_reg == hcbp_pkg::BK_EMIT && !out_full)
        begin
            win_reg <= win_reg << 8;
        end
    end

endmodule

// ----- sv/huffman_code_bit_packer_core.sv -----
// Top level of the code bit packer: front end, job queue, back end and result queue.
// An accepted request passes the front-end read registers, the job queue, the back
// end's byte window and the result queue. Loads stay in the front end; the back end
// pops an encode or flush job and emits its bytes, at most four, before the next one.
// Reset clears the table valid bits, the byte buffer and both queues at once.
module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  cmd,
    input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  out_byte,
    output logic                        last
);

    localparam int JOB_W = $bits(hcbp_pkg::job_t);
    localparam int OUT_W = $bits(hcbp_pkg::out_t);

    logic                                      job_push;
    logic                                      job_pop;
    logic                                      job_full;
    logic                                      job_empty;
    logic [$clog2(hcbp_pkg::JOB_DEPTH+1)-1:0]  job_count;
    hcbp_pkg::job_t                            job_in;
    hcbp_pkg::job_t                            job_out;
    logic                                      out_push;
    logic                                      out_full;
    hcbp_pkg::out_t                            out_in;
    hcbp_pkg::out_t                            out_head;
    logic [$clog2(hcbp_pkg::OUT_DEPTH+1)-1:0]  out_count;

    hcbp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .symbol(symbol),
        .code_bits(code_bits),
        .code_length(code_length),
        .job_count(job_count),
        .job_push(job_push),
        .job(job_in)
    );

    hcbp_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(hcbp_pkg::JOB_DEPTH)
    ) u_job_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(job_push),
        .wr_data(job_in),
        .pop(job_pop),
        .rd_data(job_out),
        .full(job_full),
        .empty(job_empty),
        .count(job_count)
    );

    hcbp_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_empty(job_empty),
        .job(job_out),
        .job_pop(job_pop),
        .out_full(out_full),
        .out_push(out_push),
        .out_item(out_in)
    );

    hcbp_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(hcbp_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .push(out_push),
        .wr_data(out_in),
        .pop(pop && !job_full | pop),
        .rd_data(out_head),
        .full(out_full),
        .empty(empty),
        .count(out_count)
    );

    assign out_byte = (out_count != '0) ? out_head.data : 8'd0;
    assign last     = (out_count != '0) ? out_head.last : 1'b0;

endmodule

// ----- sim/packer_scoreboard_pkg.sv -----
// Scoreboard for the code bit packer: table shadow, byte predictor and result checker.
`timescale 1ns / 100ps

package packer_scoreboard_pkg;

    import hcbp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_LEN = (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;

    class packer_scoreboard;

        logic [CODE_W-1:0] code_table [DEF_SYMBOL_COUNT];
        logic [LEN_W-1:0]  length_table [DEF_SYMBOL_COUNT];
        logic [7:0]        partial_byte;
        int unsigned       partial_count;
        out_t              awaited_bytes [$];
        int unsigned       mismatches;

        function new();
            foreach (length_table[k])
                length_table[k] = '0;
            partial_byte = '0;
            partial_count = 0;
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_bytes.size();
        endfunction

        function void accept_request(logic [1:0] op, logic [SYM_W-1:0] sym,
                                     logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
            out_t        produced [$];
            out_t        item;
            logic [7:0]  acc;
            int unsigned fill;
            int          nbits;
            acc = partial_byte;
            fill = partial_count;
            case (op)
                CMD_LOAD:
                begin
                    code_table[sym] = code;
                    length_table[sym] = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
                end
                CMD_FLUSH:
                begin
                    if (partial_count != 0)
                    begin
                        item.data = partial_byte;
                        item.last = 1'b1;
                        awaited_bytes = {awaited_bytes, item};
                        partial_byte = '0;
                        partial_count = 0;
                    end
                end
                CMD_ENCODE:
                begin
                    nbits = length_table[sym];
                    for (int i = nbits; i > 0; i--)
                    begin
                        acc[7 - fill] = code_table[sym][i - 1];
                        fill++;
                        if (fill == 8)
                        begin
                            item.data = acc;
                            item.last = 1'b0;
                            produced = {produced, item};
                            fill = 0;
                            acc = '0;
                        end
                    end
                    foreach (produced[k])
                    begin
                        if (k == produced.size() - 1)
                            produced[k].last = 1'b1;
                        awaited_bytes = {awaited_bytes, produced[k]};
                    end
                    partial_byte = acc;
                    partial_count = fill;
                end
                default:
                    ;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            out_t want;
            if (awaited_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %02h last %0b", $realtime, data, last);
            end
            else
            begin
                want = awaited_bytes[0];
                awaited_bytes.delete(0);
                if (want.data !== data || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: byte expected %02h last %0b, got %02h last %0b",
                                 $realtime, want.data, want.last, data, last);
                end
            end
        endfunction

    endclass

endpackage

// ----- sim/tb_top.sv -----
// Top-level testbench for the code bit packer core.
`timescale 1ns / 100ps

module tb_top;

    import hcbp_pkg::*;
    import packer_scoreboard_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              empty;
    logic              pop;
    logic [7:0]        out_byte;
    logic              last;

    packer_scoreboard sb;
    bit               steady_pop;
    bit               loaded [DEF_SYMBOL_COUNT];
    logic [SYM_W-1:0] loaded_symbols [$];

    huffman_code_bit_packer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .symbol      (symbol),
        .code_bits   (code_bits),
        .code_length (code_length),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_byte(out_byte, last);
    end

    task automatic send_request(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        push <= 1'b1;
        cmd <= op;
        symbol <= sym;
        code_bits <= code;
        code_length <= len;
        do
            @(posedge clk);
        while (full);
        sb.accept_request(op, sym, code, len);
        if (op == CMD_LOAD && !loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_symbols = {loaded_symbols, sym};
        end
        @(negedge clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic send_random_request();
        int unsigned      pick;
        int unsigned      len_pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 5)
                len = '0;
            else if (len_pick < 12)
                len = LEN_W'($urandom_range(33, 63));
            else if (len_pick < 25)
                len = LEN_W'($urandom_range(13, 32));
            else
                len = LEN_W'($urandom_range(1, 12));
            send_request(CMD_LOAD, SYM_W'($urandom), $urandom, len);
        end
        else if (pick < 85)
            send_request(CMD_ENCODE,
                         loaded_symbols[$urandom_range(0, loaded_symbols.size() - 1)],
                         $urandom, LEN_W'($urandom));
        else if (pick < 95)
            send_request(CMD_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        else
            send_request(CMD_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    endtask

    initial
    begin
        int unsigned run_len;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            run_len = $urandom_range(1, 10);
            if (!steady_pop && $urandom_range(0, 3) == 0)
                pop <= 1'b0;
            else
                pop <= 1'b1;
            repeat (run_len - 1)
                @(negedge clk);
        end
    end

    initial
    begin
        sb = new();
        steady_pop = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        cmd = CMD_ENCODE;
        symbol = '0;
        code_bits = '0;
        code_length = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
        send_request(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_request(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        send_request(CMD_LOAD, 8'd255, 32'h0000_0000, 6'd63);
        send_request(CMD_LOAD, 8'd1, 32'h0000_0005, 6'd3);
        send_request(CMD_LOAD, 8'd2, 32'hABCD_1234, 6'd0);
        send_request(CMD_LOAD, 8'd3, 32'h0000_0001, 6'd1);
        send_request(CMD_LOAD, 8'd170, 32'h0000_00A5, 6'd8);
        send_request(CMD_ENCODE, 8'd0, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd1, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd2, 32'h0, 6'd0);
        send_request(CMD_UNUSED, 8'd0, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd3, 32'h0, 6'd0);
        send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd255, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd1, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd0, 32'h0, 6'd0);
        send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd170, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd170, 32'h0, 6'd0);
        send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);
        send_request(CMD_LOAD, 8'd85, 32'hFFFF_FFF9, 6'd33);
        send_request(CMD_ENCODE, 8'd1, 32'h0, 6'd0);
        send_request(CMD_ENCODE, 8'd85, 32'h0, 6'd0);
        send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);

        for (int i = 0; i < 280; i++)
        begin
            if (i == 140)
                wait_drained();
            if (i == 240)
                steady_pop = 1'b1;
            if (i < 240 && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 10));
            send_random_request();
        end
        send_request(CMD_FLUSH, 8'd0, 32'h0, 6'd0);

        wait_drained();
        repeat (20)
            @(negedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
